// ===== hw/rtl/bsm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and constants of the twister-driven Bernoulli sampler.
// ----------------------------------------------------------------------------
package bsm_pkg;

    // twister geometry and constants
    localparam int          MT_N      = 624;
    localparam int          MT_M      = 397;
    localparam int          MT_AW     = 10;
    localparam logic [31:0] MT_MULT   = 32'd1812433253;
    localparam logic [31:0] MT_MATRIX = 32'h9908_B0DF;
    localparam logic [31:0] TEMPER_B  = 32'h9D2C_5680;
    localparam logic [31:0] TEMPER_C  = 32'hEFC6_0000;

    // k saturation value when rounding reaches 2^64
    localparam logic [63:0] K_SAT = 64'hFFFF_FFFF_FFFF_F800;

    // register indexes
    localparam logic [1:0] REG_SEED    = 2'd0;
    localparam logic [1:0] REG_IN_FMT  = 2'd1;
    localparam logic [1:0] REG_OUT_FMT = 2'd2;

    // probability encodings
    localparam logic [1:0] IN_F32 = 2'd0;
    localparam logic [1:0] IN_F64 = 2'd1;
    localparam logic [1:0] IN_F16 = 2'd2;

    // result encodings with a float one
    localparam logic [3:0] OUT_F32 = 4'd0;
    localparam logic [3:0] OUT_F64 = 4'd1;
    localparam logic [3:0] OUT_F16 = 4'd2;

    // patterns for one
    localparam logic [63:0] ONE_F32 = 64'h0000_0000_3F80_0000;
    localparam logic [63:0] ONE_F64 = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] ONE_F16 = 64'h0000_0000_0000_3C00;
    localparam logic [63:0] ONE_INT = 64'd1;

    typedef struct packed {
        logic        restart;
        logic [63:0] prob_bits;
    } in_item_t;

    typedef struct packed {
        logic        sample;
        logic [63:0] value_word;
        logic        bad_prob;
    } out_item_t;

    // classified item passed from front to back
    typedef struct packed {
        logic        restart;
        logic        bad;
        logic        is_one;
        logic [63:0] limit;
    } cmd_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SEED,
        BK_DRAW1,
        BK_CAPT1,
        BK_DRAW2,
        BK_CAPT2,
        BK_PRIME,
        BK_TWIST,
        BK_ROUND,
        BK_DONE
    } bk_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bsm_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_fifo
// Short command queue between the classifying front and the twister back.
// ----------------------------------------------------------------------------
module bsm_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr,
    input  bsm_pkg::cmd_t      wr_data,
    output logic               full,
    input  wire logic          rd,
    output bsm_pkg::cmd_t      rd_data,
    output logic               empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bsm_pkg::cmd_t  entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (rd)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (wr && !rd)
                count_reg <= count_reg + 1'b1;
            else if (rd && !wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bsm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_front
// Decodes the probability word, flags bad values and scales p to 2^64.
// ----------------------------------------------------------------------------
module bsm_front (
    input  wire logic          push,
    input  bsm_pkg::in_item_t  in_item,
    input  wire logic [1:0]    in_fmt,
    input  wire logic          q_full,
    output logic               full,
    output logic               q_wr,
    output bsm_pkg::cmd_t      q_data
);

    logic               sign;
    logic [63:0]        mag;
    logic [63:0]        one;
    logic [63:0]        m;
    logic signed [12:0] sh;
    logic [12:0]        rsh;
    logic [63:0]        mask;
    logic [63:0]        limit;

    assign full = q_full;
    assign q_wr = push && !q_full;

    // field split per encoding
    always_comb
    begin
        case (in_fmt)
            bsm_pkg::IN_F64:
            begin
                sign = in_item.prob_bits[63];
                mag  = {1'b0, in_item.prob_bits[62:0]};
                one  = bsm_pkg::ONE_F64;
                if (in_item.prob_bits[62:52] != '0)
                begin
                    m  = {11'd0, 1'b1, in_item.prob_bits[51:0]};
                    sh = $signed({2'b00, in_item.prob_bits[62:52]}) - 13'sd1011;
                end
                else
                begin
                    m  = {12'd0, in_item.prob_bits[51:0]};
                    sh = -13'sd1010;
                end
            end
            bsm_pkg::IN_F16:
            begin
                sign = in_item.prob_bits[15];
                mag  = {49'd0, in_item.prob_bits[14:0]};
                one  = bsm_pkg::ONE_F16;
                if (in_item.prob_bits[14:10] != '0)
                begin
                    m  = {53'd0, 1'b1, in_item.prob_bits[9:0]};
                    sh = $signed({8'd0, in_item.prob_bits[14:10]}) + 13'sd39;
                end
                else
                begin
                    m  = {54'd0, in_item.prob_bits[9:0]};
                    sh = 13'sd40;
                end
            end
            default:
            begin
                sign = in_item.prob_bits[31];
                mag  = {33'd0, in_item.prob_bits[30:0]};
                one  = bsm_pkg::ONE_F32;
                if (in_item.prob_bits[30:23] != '0)
                begin
                    m  = {40'd0, 1'b1, in_item.prob_bits[22:0]};
                    sh = $signed({5'd0, in_item.prob_bits[30:23]}) - 13'sd86;
                end
                else
                begin
                    m  = {41'd0, in_item.prob_bits[22:0]};
                    sh = -13'sd85;
                end
            end
        endcase
    end

    // ceil(p * 2^64) for p below one
    always_comb
    begin
        rsh  = 13'(-sh);
        mask = (64'd1 << rsh[5:0]) - 64'd1;
        if (m == '0)
            limit = '0;
        else if (sh >= 0)
            limit = m << sh[5:0];
        else if (rsh >= 13'd64)
            limit = 64'd1;
        else
            limit = (m >> rsh[5:0]) + {63'd0, |(m & mask)};
    end

    assign q_data.restart = in_item.restart;
    assign q_data.bad     = (sign && mag != '0) || (mag > one);
    assign q_data.is_one  = (mag == one);
    assign q_data.limit   = limit;

endmodule

`default_nettype wire

// ===== hw/rtl/bsm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_back
// Twister state memory, seeding and refill sequencer, draws and result word.
// ----------------------------------------------------------------------------
module bsm_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  bsm_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    input  wire logic [31:0]   seed,
    input  wire logic [3:0]    out_fmt,
    output logic               out_valid,
    output bsm_pkg::out_item_t out_item,
    input  wire logic          out_pop
);

    localparam int AW = bsm_pkg::MT_AW;

    bsm_pkg::bk_state_t state_reg, state_next;
    bsm_pkg::cmd_t      cmd_reg;
    logic [AW-1:0]      idx_reg;
    logic [AW-1:0]      cnt_reg;
    logic [31:0]        prev_reg;
    logic               hi_reg;
    logic               second_reg;
    logic [31:0]        g1_reg;
    logic [31:0]        g2_reg;
    logic [63:0]        k_reg;
    logic               out_valid_reg;
    bsm_pkg::out_item_t out_reg;

    logic [31:0]        mem [bsm_pkg::MT_N];
    logic [31:0]        rda_reg;
    logic [31:0]        rdb_reg;
    logic [AW-1:0]      ra;
    logic [AW-1:0]      rb;
    logic               we;
    logic [AW-1:0]      wa;
    logic [31:0]        wd;

    logic               slot_free;
    logic               sample;
    logic [31:0]        seed_val;
    logic [31:0]        twist_y;
    logic [31:0]        twist_val;
    logic [AW:0]        far_sum;

    localparam logic [AW-1:0] N_IDX = AW'(bsm_pkg::MT_N);

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & bsm_pkg::TEMPER_B);
        y = y ^ ((y << 15) & bsm_pkg::TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // round to 53 significant bits, ties to even
    function automatic logic [63:0] round53(input logic [63:0] s);
        logic [3:0]  drop;
        logic [63:0] low;
        logic [63:0] half;
        logic [63:0] q;
        logic [63:0] r;
        drop = '0;
        for (int p = 53; p <= 63; p++)
        begin
            if (s[p])
                drop = 4'(p - 52);
        end
        low  = s & ((64'd1 << drop) - 64'd1);
        half = 64'd1 << (drop - 4'd1);
        q    = s >> drop;
        if (low > half || (low == half && q[0]))
            q = q + 64'd1;
        if (drop == '0)
            r = s;
        else if (drop == 4'd11 && q == (64'd1 << 53))
            r = bsm_pkg::K_SAT;
        else
            r = q << drop;
        return r;
    endfunction

    assign slot_free = !out_valid_reg || out_pop;
    assign seed_val  = bsm_pkg::MT_MULT * (prev_reg ^ (prev_reg >> 30)) + 32'(cnt_reg);
    assign twist_y   = {hi_reg, rda_reg[30:0]};
    assign twist_val = rdb_reg ^ (twist_y >> 1) ^ (twist_y[0] ? bsm_pkg::MT_MATRIX : 32'd0);
    assign far_sum   = {1'b0, cnt_reg} + (AW + 1)'(bsm_pkg::MT_M);
    assign sample    = !cmd_reg.bad && (cmd_reg.is_one || (k_reg < cmd_reg.limit));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bsm_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.restart)
                        state_next = bsm_pkg::BK_SEED;
                    else if (cmd.bad)
                        state_next = bsm_pkg::BK_DONE;
                    else
                        state_next = bsm_pkg::BK_DRAW1;
                end
            end
            bsm_pkg::BK_SEED:
            begin
                if (cnt_reg == N_IDX - 1'b1)
                    state_next = cmd_reg.bad ? bsm_pkg::BK_DONE : bsm_pkg::BK_DRAW1;
            end
            bsm_pkg::BK_DRAW1:
                state_next = (idx_reg == N_IDX) ? bsm_pkg::BK_PRIME : bsm_pkg::BK_CAPT1;
            bsm_pkg::BK_CAPT1:
                state_next = bsm_pkg::BK_DRAW2;
            bsm_pkg::BK_DRAW2:
                state_next = (idx_reg == N_IDX) ? bsm_pkg::BK_PRIME : bsm_pkg::BK_CAPT2;
            bsm_pkg::BK_CAPT2:
                state_next = bsm_pkg::BK_ROUND;
            bsm_pkg::BK_PRIME:
                state_next = bsm_pkg::BK_TWIST;
            bsm_pkg::BK_TWIST:
            begin
                if (cnt_reg == N_IDX)
                    state_next = second_reg ? bsm_pkg::BK_DRAW2 : bsm_pkg::BK_DRAW1;
            end
            bsm_pkg::BK_ROUND:
                state_next = bsm_pkg::BK_DONE;
            bsm_pkg::BK_DONE:
            begin
                if (slot_free)
                    state_next = bsm_pkg::BK_IDLE;
            end
            default:
                state_next = bsm_pkg::BK_IDLE;
        endcase
    end

    // memory and queue control
    always_comb
    begin
        cmd_pop = 1'b0;
        ra      = '0;
        rb      = '0;
        we      = 1'b0;
        wa      = '0;
        wd      = '0;
        case (state_reg)
            bsm_pkg::BK_IDLE:
                cmd_pop = cmd_valid;
            bsm_pkg::BK_SEED:
            begin
                we = 1'b1;
                wa = cnt_reg;
                wd = (cnt_reg == '0) ? seed : seed_val;
            end
            bsm_pkg::BK_DRAW1, bsm_pkg::BK_DRAW2:
                ra = idx_reg;
            bsm_pkg::BK_TWIST:
            begin
                ra = (cnt_reg == N_IDX - 1'b1) ? '0 : cnt_reg + 1'b1;
                rb = (far_sum >= (AW + 1)'(bsm_pkg::MT_N)) ?
                     AW'(far_sum - (AW + 1)'(bsm_pkg::MT_N)) : AW'(far_sum);
                if (cnt_reg != '0)
                begin
                    we = 1'b1;
                    wa = cnt_reg - 1'b1;
                    wd = twist_val;
                end
            end
            default:
            begin
                ra = '0;
            end
        endcase
    end

    // state memory
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rda_reg <= mem[ra];
        rdb_reg <= mem[rb];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bsm_pkg::BK_IDLE;
            idx_reg       <= N_IDX;
            cnt_reg       <= '0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                bsm_pkg::BK_IDLE:
                    cnt_reg <= '0;
                bsm_pkg::BK_SEED:
                begin
                    if (cnt_reg == N_IDX - 1'b1)
                    begin
                        cnt_reg <= '0;
                        idx_reg <= N_IDX;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                bsm_pkg::BK_DRAW1, bsm_pkg::BK_DRAW2:
                begin
                    if (idx_reg == N_IDX)
                    begin
                        second_reg <= (state_reg == bsm_pkg::BK_DRAW2);
                        cnt_reg    <= '0;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                bsm_pkg::BK_TWIST:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == N_IDX)
                        idx_reg <= '0;
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
            if (state_reg == bsm_pkg::BK_DONE && slot_free)
                out_valid_reg <= 1'b1;
            else if (out_pop)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == bsm_pkg::BK_IDLE && cmd_valid)
            cmd_reg <= cmd;
        if (state_reg == bsm_pkg::BK_SEED)
            prev_reg <= wd;
        if (state_reg == bsm_pkg::BK_TWIST)
            hi_reg <= rda_reg[31];
        if (state_reg == bsm_pkg::BK_CAPT1)
            g1_reg <= temper(rda_reg);
        if (state_reg == bsm_pkg::BK_CAPT2)
            g2_reg <= temper(rda_reg);
        if (state_reg == bsm_pkg::BK_ROUND)
            k_reg <= round53({g2_reg, g1_reg});
        if (state_reg == bsm_pkg::BK_DONE && slot_free)
        begin
            out_reg.sample   <= sample;
            out_reg.bad_prob <= cmd_reg.bad;
            if (!sample)
                out_reg.value_word <= '0;
            else
            begin
                case (out_fmt)
                    bsm_pkg::OUT_F32: out_reg.value_word <= bsm_pkg::ONE_F32;
                    bsm_pkg::OUT_F64: out_reg.value_word <= bsm_pkg::ONE_F64;
                    bsm_pkg::OUT_F16: out_reg.value_word <= bsm_pkg::ONE_F16;
                    default:          out_reg.value_word <= bsm_pkg::ONE_INT;
                endcase
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // twister index never passes the table size
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= N_IDX)
        else $error("twister index out of range");

    // a bad word carries a zero sample and a zero value
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.bad_prob |-> !out_reg.sample && out_reg.value_word == '0)
        else $error("bad probability with nonzero result");

    // a popped command always leaves idle
    a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> state_reg != bsm_pkg::BK_IDLE)
        else $error("command popped but back stayed idle");

endmodule

`default_nettype wire

// ===== hw/rtl/bernoulli_sampler_mt19937_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bernoulli_sampler_mt19937_unit
// Bernoulli sampler fed by a 32-bit Mersenne twister.
// ----------------------------------------------------------------------------
// Input words are pushed with push/full; each carries a raw probability and a
// restart flag. Results are taken with empty/pop; the oldest result shows on
// out_item while empty is low. Registers (seed, in_format, out_format) are
// written through cfg_we/cfg_addr/cfg_data; the user must write them only
// while the unit is idle, which the unit does not enforce. A front stage
// classifies each word (bad value, one, scaled limit) and puts it in a short
// queue; the back sequencer owns the 624-word state memory. A valid word
// goes through two draws from the state memory, a rounding step and the
// compare in the back; a bad word skips the draws. A restart adds seeding
// of all 624 state words, one per cycle through the multiplier; the first
// valid word after it, and every 312th one after that, adds a state refill.
// Reset clears the registers to zero and marks the state as needing refill;
// the state memory itself holds nothing until the first restart.
// When the receiver stalls, one result waits in the output register, the
// back holds its next result and the queue fills before full rises.
// ----------------------------------------------------------------------------
module bernoulli_sampler_mt19937_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  bsm_pkg::in_item_t  in_item,
    output logic               empty,
    input  wire logic          pop,
    output bsm_pkg::out_item_t out_item,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_addr,
    input  wire logic [31:0]   cfg_data
);

    logic [31:0]   seed_reg;
    logic [1:0]    in_fmt_reg;
    logic [3:0]    out_fmt_reg;

    logic          q_wr;
    logic          q_full;
    logic          q_empty;
    logic          q_rd;
    bsm_pkg::cmd_t q_wdata;
    bsm_pkg::cmd_t q_rdata;
    logic          out_valid;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg    <= '0;
            in_fmt_reg  <= '0;
            out_fmt_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                bsm_pkg::REG_SEED:    seed_reg    <= cfg_data;
                bsm_pkg::REG_IN_FMT:  in_fmt_reg  <= cfg_data[1:0];
                bsm_pkg::REG_OUT_FMT: out_fmt_reg <= cfg_data[3:0];
                default:              seed_reg    <= seed_reg;
            endcase
        end
    end

    bsm_front u_front (
        .push    (push),
        .in_item (in_item),
        .in_fmt  (in_fmt_reg),
        .q_full  (q_full),
        .full    (full),
        .q_wr    (q_wr),
        .q_data  (q_wdata)
    );

    bsm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd      (q_rd),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    bsm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (q_rdata),
        .cmd_pop   (q_rd),
        .seed      (seed_reg),
        .out_fmt   (out_fmt_reg),
        .out_valid (out_valid),
        .out_item  (out_item),
        .out_pop   (pop)
    );

    assign empty = !out_valid;

endmodule

`default_nettype wire

// ===== verif/bsm_sample_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_sample_checker
// Watches the input, result and register ports of the Bernoulli sampler. It
// keeps its own twister state and register copy, predicts one result word
// per accepted input word, and compares each popped word field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
module bsm_sample_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  bsm_pkg::in_item_t   in_item,
    input  logic                empty,
    input  logic                pop,
    input  bsm_pkg::out_item_t  out_item,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [31:0]         cfg_data,
    output int                  errors,
    output int                  pending,
    output int                  results_seen,
    output int                  bad_seen,
    output int                  reseeds_seen
);

    // register copies
    logic [31:0] seed_reg;
    logic [1:0]  in_fmt;
    logic [3:0]  out_fmt;

    // twister copy
    logic [31:0] mt_state [bsm_pkg::MT_N];
    int          mt_pos;

    bsm_pkg::out_item_t expected_samples [$];

    // fill the state words from a seed
    function automatic void seed_twister(logic [31:0] s);
        logic [31:0] p;
        mt_state[0] = s;
        for (int i = 1; i < bsm_pkg::MT_N; i++)
        begin
            p = mt_state[i - 1];
            mt_state[i] = bsm_pkg::MT_MULT * (p ^ (p >> 30)) + 32'(i);
        end
        mt_pos = bsm_pkg::MT_N;
    endfunction

    // regenerate all state words in place
    function automatic void twist_state();
        logic [31:0] y;
        logic [31:0] v;
        for (int i = 0; i < bsm_pkg::MT_N; i++)
        begin
            y = (mt_state[i] & 32'h8000_0000) |
                (mt_state[(i + 1) % bsm_pkg::MT_N] & 32'h7FFF_FFFF);
            v = mt_state[(i + bsm_pkg::MT_M) % bsm_pkg::MT_N] ^ (y >> 1);
            if (y[0])
                v = v ^ bsm_pkg::MT_MATRIX;
            mt_state[i] = v;
        end
        mt_pos = 0;
    endfunction

    // one tempered 32-bit draw
    function automatic logic [31:0] draw_word();
        logic [31:0] y;
        if (mt_pos >= bsm_pkg::MT_N)
            twist_state();
        y = mt_state[mt_pos];
        mt_pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & bsm_pkg::TEMPER_B);
        y = y ^ ((y << 15) & bsm_pkg::TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // round to 53 significant bits, ties to even, saturating below 2^64
    function automatic logic [63:0] round_to_53(logic [63:0] s);
        int          msb;
        int          drop;
        logic [63:0] low;
        logic [63:0] half;
        logic [63:0] q;
        if (s < (64'd1 << 53))
            return s;
        msb = 63;
        while (!s[msb])
            msb--;
        drop = msb - 52;
        low  = s & ((64'd1 << drop) - 64'd1);
        half = 64'd1 << (drop - 1);
        q    = s >> drop;
        if (low > half || (low == half && q[0]))
            q = q + 64'd1;
        if (drop == 11 && q == (64'd1 << 53))
            return bsm_pkg::K_SAT;
        return q << drop;
    endfunction

    // ceil(m * 2^e * 2^64) for a probability below one
    function automatic logic [63:0] threshold_of(logic [63:0] m, int e);
        int sh;
        int s;
        sh = e + 64;
        if (m == 64'd0)
            return 64'd0;
        if (sh >= 0)
            return m << sh;
        s = -sh;
        if (s >= 64)
            return 64'd1;
        return (m >> s) + (((m & ((64'd1 << s) - 64'd1)) != 64'd0) ? 64'd1 : 64'd0);
    endfunction

    // expected result word for one accepted input word
    function automatic bsm_pkg::out_item_t predict_sample(bsm_pkg::in_item_t w);
        bsm_pkg::out_item_t r;
        logic [63:0] b;
        logic [63:0] mag;
        logic [63:0] one;
        logic [63:0] m;
        logic [63:0] k;
        logic        sgn;
        int          ex;
        int          e;
        logic [31:0] g1;
        logic [31:0] g2;
        b = w.prob_bits;
        if (w.restart)
            seed_twister(seed_reg);
        case (in_fmt)
            bsm_pkg::IN_F64:
            begin
                sgn = b[63];
                mag = {1'b0, b[62:0]};
                one = bsm_pkg::ONE_F64;
                ex  = int'(mag[62:52]);
                m   = (ex != 0) ? ({12'd0, mag[51:0]} | (64'd1 << 52)) : {12'd0, mag[51:0]};
                e   = (ex != 0) ? ex - 1075 : -1074;
            end
            bsm_pkg::IN_F16:
            begin
                sgn = b[15];
                mag = {49'd0, b[14:0]};
                one = bsm_pkg::ONE_F16;
                ex  = int'(mag[14:10]);
                m   = (ex != 0) ? ({54'd0, mag[9:0]} | 64'h400) : {54'd0, mag[9:0]};
                e   = (ex != 0) ? ex - 25 : -24;
            end
            default:
            begin
                sgn = b[31];
                mag = {33'd0, b[30:0]};
                one = bsm_pkg::ONE_F32;
                ex  = int'(mag[30:23]);
                m   = (ex != 0) ? ({41'd0, mag[22:0]} | 64'h80_0000) : {41'd0, mag[22:0]};
                e   = (ex != 0) ? ex - 150 : -149;
            end
        endcase
        r = '0;
        if ((sgn && mag != 64'd0) || mag > one)
        begin
            r.bad_prob = 1'b1;
            return r;
        end
        g1 = draw_word();
        g2 = draw_word();
        k  = round_to_53({g2, g1});
        r.sample = (mag == one) ? 1'b1 : (k < threshold_of(m, e));
        if (r.sample)
        begin
            case (out_fmt)
                bsm_pkg::OUT_F32: r.value_word = bsm_pkg::ONE_F32;
                bsm_pkg::OUT_F64: r.value_word = bsm_pkg::ONE_F64;
                bsm_pkg::OUT_F16: r.value_word = bsm_pkg::ONE_F16;
                default:          r.value_word = bsm_pkg::ONE_INT;
            endcase
        end
        return r;
    endfunction

    // track registers, predict on push, compare on pop
    always @(posedge clk or negedge rst_n)
    begin
        bsm_pkg::out_item_t x;
        if (!rst_n)
        begin
            seed_reg     <= '0;
            in_fmt       <= bsm_pkg::IN_F32;
            out_fmt      <= bsm_pkg::OUT_F32;
            mt_pos       = bsm_pkg::MT_N;
            errors       <= 0;
            pending      <= 0;
            results_seen <= 0;
            bad_seen     <= 0;
            reseeds_seen <= 0;
            expected_samples.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                results_seen <= results_seen + 1;
                if (expected_samples.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: result word with nothing expected: %p", $realtime,
                                 out_item);
                    errors <= errors + 1;
                end
                else
                begin
                    x = expected_samples.pop_front();
                    if (x.sample !== out_item.sample || x.value_word !== out_item.value_word ||
                        x.bad_prob !== out_item.bad_prob)
                    begin
                        if (errors < 10)
                            $display("%0t: mismatch sample %b/%b value %h/%h bad %b/%b",
                                     $realtime, x.sample, out_item.sample, x.value_word,
                                     out_item.value_word, x.bad_prob, out_item.bad_prob);
                        errors <= errors + 1;
                    end
                end
            end
            if (push && !full)
            begin
                x = predict_sample(in_item);
                expected_samples.push_back(x);
                if (x.bad_prob)
                    bad_seen <= bad_seen + 1;
                if (in_item.restart)
                    reseeds_seen <= reseeds_seen + 1;
            end
            pending <= expected_samples.size();
            if (cfg_we)
            begin
                case (cfg_addr)
                    bsm_pkg::REG_SEED:    seed_reg <= cfg_data;
                    bsm_pkg::REG_IN_FMT:  in_fmt   <= cfg_data[1:0];
                    bsm_pkg::REG_OUT_FMT: out_fmt  <= cfg_data[3:0];
                    default:              ;
                endcase
            end
        end
    end

endmodule

// ===== verif/tb_bernoulli_sampler_mt19937_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bernoulli_sampler_mt19937_unit
// Drives probability words in all three encodings, reseeds and register
// settings into the sampler under random sender and receiver idling plus one
// long receiver hold-off; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_bernoulli_sampler_mt19937_unit;

    localparam int STALL_LIMIT = 30000;
    localparam int BATCHES     = 7;
    localparam int BATCH_WORDS = 250;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    bsm_pkg::in_item_t  in_item = '0;
    logic               empty;
    logic               pop = 1'b0;
    bsm_pkg::out_item_t out_item;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_addr = bsm_pkg::REG_SEED;
    logic [31:0]        cfg_data = '0;

    int errors;
    int pending;
    int results_seen;
    int bad_seen;
    int reseeds_seen;
    int tx_idle = 0;
    int rx_idle = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;
    logic [1:0] cur_in_fmt = bsm_pkg::IN_F32;

    always #5 clk = ~clk;

    bernoulli_sampler_mt19937_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    bsm_sample_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .in_item      (in_item),
        .empty        (empty),
        .pop          (pop),
        .out_item     (out_item),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen),
        .bad_seen     (bad_seen),
        .reseeds_seen (reseeds_seen)
    );

    // receiver: random pop, or a long hold-off when asked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                pop <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end
            else
                pop <= ($urandom_range(99) >= rx_idle);
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // offer one word and hold it until accepted
    task automatic send_word(logic restart, logic [63:0] prob);
        while ($urandom_range(99) < tx_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        in_item <= '{restart: restart, prob_bits: prob};
        push    <= 1'b1;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every expected word has come back, then let the back settle
    task automatic drain();
        push <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // probability pattern for the current encoding, mostly in range
    function automatic logic [63:0] pick_prob();
        logic [63:0] noise;
        int          sel;
        noise = {$urandom, $urandom};
        sel   = $urandom_range(99);
        if (sel < 12)
            return noise;
        case (cur_in_fmt)
            bsm_pkg::IN_F64:
            begin
                if (sel < 16) return bsm_pkg::ONE_F64;
                if (sel < 19) return 64'h8000_0000_0000_0000;
                if (sel < 22) return 64'h7FF8_0000_0000_0001;
                if (sel < 40) return {2'b00, 10'h3FE, noise[51:0]};
                return {1'b0, noise[62:0]} % (bsm_pkg::ONE_F64 + 64'd1);
            end
            bsm_pkg::IN_F16:
            begin
                if (sel < 16) return {noise[63:16], 16'h3C00};
                if (sel < 19) return {noise[63:16], 16'h8000};
                if (sel < 22) return {noise[63:16], 16'h7E01};
                return {noise[63:16], 16'($urandom_range(16'h3C00))};
            end
            default:
            begin
                if (sel < 16) return {noise[63:32], 32'h3F80_0000};
                if (sel < 19) return {noise[63:32], 32'h8000_0000};
                if (sel < 22) return {noise[63:32], 32'h7FC0_0001};
                if (sel < 40) return {noise[63:32], 2'b00, 7'h7E, noise[22:0]};
                return {noise[63:32], 32'($urandom_range(32'h3F80_0000))};
            end
        endcase
    endfunction

    initial
    begin
        logic [63:0] directed [] = '{
            64'h0, 64'h8000_0000, 64'h3F80_0000, 64'h3F80_0001, 64'h7FC0_0000,
            64'h7F80_0000, 64'hBF80_0000, 64'h1, 64'h3F7F_FFFF, 64'h3F00_0000,
            64'hFFFF_FFFF_0000_0000, 64'h007F_FFFF, 64'h0080_0000, 64'h3E80_0000,
            64'hFFFF_FFFF_3F80_0000, 64'h8000_0001};
        logic [31:0] seeds [] = '{32'hFFFF_FFFF, 32'd5489, 32'h0, 32'h1234_5678};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed float32 corners, first and tenth words reseed
        write_reg(bsm_pkg::REG_SEED, 32'd0);
        write_reg(bsm_pkg::REG_IN_FMT, {30'd0, bsm_pkg::IN_F32});
        write_reg(bsm_pkg::REG_OUT_FMT, {28'd0, bsm_pkg::OUT_F32});
        for (int i = 0; i < directed.size(); i++)
            send_word(i == 0 || i == 9, directed[i]);
        drain();

        // float64 and float16 one, smallest subnormal and just-out-of-range
        cur_in_fmt = bsm_pkg::IN_F64;
        write_reg(bsm_pkg::REG_IN_FMT, {30'd0, bsm_pkg::IN_F64});
        write_reg(bsm_pkg::REG_OUT_FMT, {28'd0, bsm_pkg::OUT_F64});
        send_word(1'b0, bsm_pkg::ONE_F64);
        send_word(1'b0, bsm_pkg::ONE_F64 + 64'd1);
        send_word(1'b0, 64'h0000_0000_0000_0001);
        drain();
        cur_in_fmt = bsm_pkg::IN_F16;
        write_reg(bsm_pkg::REG_IN_FMT, {30'd0, bsm_pkg::IN_F16});
        write_reg(bsm_pkg::REG_OUT_FMT, {28'd0, bsm_pkg::OUT_F16});
        send_word(1'b0, bsm_pkg::ONE_F16);
        send_word(1'b0, 64'h3C01);
        send_word(1'b1, 64'h0001);
        drain();

        // random batches, each under its own register setting
        for (int b = 0; b < BATCHES; b++)
        begin
            if (b < 3)
            begin
                tx_idle = 11;
                rx_idle = 83;
            end
            else if (b < 5)
            begin
                tx_idle = 83;
                rx_idle = 11;
            end
            else
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            cur_in_fmt = (b == 6) ? 2'd3 : 2'(b % 3);
            write_reg(bsm_pkg::REG_SEED, (b < seeds.size()) ? seeds[b] : $urandom);
            write_reg(bsm_pkg::REG_IN_FMT, {30'd0, cur_in_fmt});
            write_reg(bsm_pkg::REG_OUT_FMT, (b == 0) ? 32'd15 : 32'($urandom_range(15)));
            for (int i = 0; i < BATCH_WORDS; i++)
            begin
                // long receiver hold-off so the input backs up
                if (b == 5 && i == 20)
                    hold_cycles = 400;
                send_word(i == 0 || $urandom_range(99) < 3, pick_prob());
            end
            drain();
        end

        repeat (50) @(posedge clk);
        $display("covered %0d result words, %0d bad probabilities, %0d reseeds",
                 results_seen, bad_seen, reseeds_seen);
        $display("three encodings, all output types, idle mixes and one long hold-off");
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== bernoulli_sampler_mt19937_unit.f =====
hw/rtl/bsm_pkg.sv
hw/rtl/bsm_fifo.sv
hw/rtl/bsm_front.sv
hw/rtl/bsm_back.sv
hw/rtl/bernoulli_sampler_mt19937_unit.sv
verif/bsm_sample_checker.sv
verif/tb_bernoulli_sampler_mt19937_unit.sv
